// File: rtl/first_fit_heap_allocator_top_assert.svh
// assertion macros for the first-fit heap allocator
// used by the controller module; no other dependencies
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFHA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFHA_ASSERT(label, clk, rst_n, prop, msg)
`define FFHA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// used by ffha_ctrl, ffha_dpath and the top level
package ffha_pkg;
    localparam int HeapBytes     = 65536;
    localparam int EntryHdrBytes = 48;
    localparam int PoolHdrBytes  = 24;
    localparam int MaxBlocks     = 64;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NO_FIT       = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL   = 2'd2;
    localparam logic [1:0] ST_FREE_IGNORED = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;     // latch request, point cursor at head
        logic rd;        // read record at cursor
        logic fetch_nx;  // read record at next link of cursor
        logic advance;   // cursor follows next link
        logic mark_used;
        logic do_split;
        logic do_free;
        logic do_merge;
        logic ld_result;
        logic [1:0] res_status;
        logic res_grant;
        logic ld_out;    // move finished result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic req_zero;
        logic addr_zero;
        logic used;
        logic exact;
        logic fits;
        logic slot_ok;
        logic addr_hit;
        logic link_ok;
        logic nx_link_ok;
        logic nx_used;
    } t_stat;
endpackage

// File: rtl/ffha_dpath.sv
// datapath: record tables, cursor, free slot search and split/merge arithmetic
// depends on ffha_pkg
module ffha_dpath #(
    parameter int HEAP_BYTES      = ffha_pkg::HeapBytes,
    parameter int ENTRY_HDR_BYTES = ffha_pkg::EntryHdrBytes,
    parameter int POOL_HDR_BYTES  = ffha_pkg::PoolHdrBytes,
    parameter int MAX_BLOCKS      = ffha_pkg::MaxBlocks
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_func,
    input  logic [15:0]      i_request_size,
    input  logic [15:0]      i_release_addr,
    input  ffha_pkg::t_cmd   i_cmd,
    output ffha_pkg::t_stat  o_stat,
    output logic [15:0]      o_granted_addr,
    output logic [1:0]       o_status
);
    localparam int LW = 7;
    localparam int SW = $clog2(MAX_BLOCKS);
    localparam logic [LW-1:0] NIL = 7'd127;
    localparam logic [15:0] OFS0 = 16'(POOL_HDR_BYTES + ENTRY_HDR_BYTES);
    localparam logic [15:0] SZ0  = 16'(HEAP_BYTES - POOL_HDR_BYTES - ENTRY_HDR_BYTES);
    localparam logic [16:0] HDR  = 17'(ENTRY_HDR_BYTES);

    logic [15:0]   mem_ofs  [MAX_BLOCKS];
    logic [15:0]   mem_size [MAX_BLOCKS];
    logic [LW-1:0] mem_next [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_used, r_busy;

    logic          r_func;
    logic [15:0]   r_req, r_addr;
    logic [LW-1:0] r_cur;
    logic [15:0]   r_ofs, r_size, r_nx_size;
    logic [LW-1:0] r_next, r_nx_next;
    logic [15:0]   r_grant;
    logic [1:0]    r_status;
    logic [15:0]   r_out_grant;
    logic [1:0]    r_out_status;

    // first clear slot, priority encoded
    logic [LW-1:0] free_slot;
    logic          slot_ok;
    always_comb begin
        free_slot = NIL;
        slot_ok   = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_slot = LW'(i);
                slot_ok   = 1'b1;
            end
        end
    end

    function automatic logic lv(input logic [LW-1:0] l);
        return 32'(l) < MAX_BLOCKS;
    endfunction

    logic [16:0] need;
    logic [16:0] left;
    logic [16:0] new_ofs;
    logic [16:0] merged;
    logic [SW-1:0] cur_i, nx_i, slot_i;
    assign need    = {1'b0, r_req} + HDR;
    assign left    = {1'b0, r_size} - need;
    assign new_ofs = {1'b0, r_ofs} + left + HDR;
    assign merged  = {1'b0, r_size} + {1'b0, r_nx_size} + HDR;
    assign cur_i   = r_cur[SW-1:0];
    assign nx_i    = r_next[SW-1:0];
    assign slot_i  = free_slot[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_busy <= MAX_BLOCKS'(1);
            mem_ofs[0]  <= OFS0;
            mem_size[0] <= SZ0;
            mem_next[0] <= NIL;
        end else begin
            if (i_cmd.mark_used) r_used[cur_i] <= 1'b1;
            if (i_cmd.do_split) begin
                mem_size[cur_i]  <= left[15:0];
                mem_ofs[slot_i]  <= new_ofs[15:0];
                mem_size[slot_i] <= r_req;
                mem_next[slot_i] <= r_next;
                mem_next[cur_i]  <= free_slot;
                r_used[slot_i]   <= 1'b1;
                r_busy[slot_i]   <= 1'b1;
            end
            if (i_cmd.do_free) r_used[cur_i] <= 1'b0;
            if (i_cmd.do_merge) begin
                mem_size[cur_i] <= merged[15:0];
                mem_next[cur_i] <= r_nx_next;
                r_busy[nx_i]    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_func;
            r_req  <= i_request_size;
            r_addr <= i_release_addr;
            r_cur  <= '0;
        end else if (i_cmd.advance) begin
            r_cur <= r_next;
        end
        if (i_cmd.rd) begin
            r_ofs  <= mem_ofs[cur_i];
            r_size <= mem_size[cur_i];
            r_next <= mem_next[cur_i];
        end
        if (i_cmd.fetch_nx) begin
            r_nx_size <= mem_size[nx_i];
            r_nx_next <= mem_next[nx_i];
        end
        if (i_cmd.ld_result) begin
            r_status <= i_cmd.res_status;
            r_grant  <= i_cmd.res_grant ? (i_cmd.do_split ? new_ofs[15:0] : r_ofs) : 16'd0;
        end
        // output register holds steady while a result transfer waits
        if (i_cmd.ld_out) begin
            r_out_status <= r_status;
            r_out_grant  <= r_grant;
        end
    end

    assign o_stat.func       = r_func;
    assign o_stat.req_zero   = r_req == 16'd0;
    assign o_stat.addr_zero  = r_addr == 16'd0;
    assign o_stat.used       = r_used[cur_i];
    assign o_stat.exact      = r_size == r_req;
    assign o_stat.fits       = {1'b0, r_size} >= need;
    assign o_stat.slot_ok    = slot_ok;
    assign o_stat.addr_hit   = r_ofs == r_addr;
    assign o_stat.link_ok    = lv(r_cur);
    assign o_stat.nx_link_ok = lv(r_next);
    assign o_stat.nx_used    = r_used[nx_i];
    assign o_granted_addr    = r_out_grant;
    assign o_status          = r_out_status;
endmodule

// File: rtl/ffha_ctrl.sv
// controller: request handshake and chain walk sequencing
// depends on ffha_pkg and first_fit_heap_allocator_top_assert.svh
`include "first_fit_heap_allocator_top_assert.svh"
module ffha_ctrl #(
    parameter int MAX_BLOCKS = ffha_pkg::MaxBlocks
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_MERGE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam int VW = $clog2(MAX_BLOCKS + 1);

    t_state r_state, n_state;
    logic [VW-1:0] r_visits, n_visits;
    logic r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_visits    = r_visits;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_visits    = '0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.ld_result = 1'b1;
                n_state         = S_DONE;
                if (i_stat.func == ffha_pkg::FUNC_ALLOC) begin
                    o_cmd.res_status = ffha_pkg::ST_NO_FIT;
                    if (i_stat.req_zero || !i_stat.link_ok || r_visits == VW'(MAX_BLOCKS)) begin
                        o_cmd.res_status = ffha_pkg::ST_NO_FIT;
                    end else if (!i_stat.used && i_stat.exact) begin
                        o_cmd.mark_used  = 1'b1;
                        o_cmd.res_grant  = 1'b1;
                        o_cmd.res_status = ffha_pkg::ST_OK;
                    end else if (!i_stat.used && i_stat.fits) begin
                        if (i_stat.slot_ok) begin
                            o_cmd.do_split   = 1'b1;
                            o_cmd.res_grant  = 1'b1;
                            o_cmd.res_status = ffha_pkg::ST_OK;
                        end else begin
                            o_cmd.res_status = ffha_pkg::ST_TABLE_FULL;
                        end
                    end else begin
                        o_cmd.ld_result = 1'b0;
                        o_cmd.advance   = 1'b1;
                        n_visits        = r_visits + VW'(1);
                        n_state         = S_READ;
                    end
                end else begin
                    o_cmd.res_status = ffha_pkg::ST_FREE_IGNORED;
                    if (i_stat.addr_zero || !i_stat.link_ok || r_visits == VW'(MAX_BLOCKS)) begin
                        o_cmd.res_status = ffha_pkg::ST_FREE_IGNORED;
                    end else if (i_stat.addr_hit) begin
                        if (i_stat.used) begin
                            o_cmd.do_free    = 1'b1;
                            o_cmd.res_status = ffha_pkg::ST_OK;
                            o_cmd.fetch_nx   = 1'b1;
                            n_state          = S_MERGE;
                        end
                    end else begin
                        o_cmd.ld_result = 1'b0;
                        o_cmd.advance   = 1'b1;
                        n_visits        = r_visits + VW'(1);
                        n_state         = S_READ;
                    end
                end
            end
            S_MERGE: begin
                if (i_stat.nx_link_ok && !i_stat.nx_used) o_cmd.do_merge = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_visits    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_visits    <= n_visits;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    `FFHA_ASSERT(a_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `FFHA_ASSERT(a_visits, i_clk, i_rst_n, r_visits <= VW'(MAX_BLOCKS), "walk overran")
    `FFHA_ASSERT(a_single_op, i_clk, i_rst_n,
        !(o_cmd.do_split && (o_cmd.mark_used || o_cmd.do_free)), "conflicting updates")
    `FFHA_ASSERT(a_done_out, i_clk, i_rst_n,
        (r_state == S_DONE && n_state == S_IDLE) |=> o_out_valid, "result lost")
endmodule

// File: rtl/first_fit_heap_allocator_top.sv
// first-fit heap allocator with tail splitting and forward merging
// each request walks the record chain from the head; a free that releases a block adds a merge step
// one request at a time; the record walk (one read and one evaluate per record) and a stalled output set rate
// a finished result may wait in the output register while the block returns to idle
// synchronous active-low reset restores the single free block covering the heap
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES      = ffha_pkg::HeapBytes,
    parameter int ENTRY_HDR_BYTES = ffha_pkg::EntryHdrBytes,
    parameter int POOL_HDR_BYTES  = ffha_pkg::PoolHdrBytes,
    parameter int MAX_BLOCKS      = ffha_pkg::MaxBlocks
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // func[0], request_size[16:1], release_addr[32:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // granted_addr[15:0], status[17:16]
);
    ffha_pkg::t_cmd  cmd;
    ffha_pkg::t_stat stat;
    logic [15:0] granted;
    logic [1:0]  status;

    ffha_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    ffha_dpath #(
        .HEAP_BYTES(HEAP_BYTES), .ENTRY_HDR_BYTES(ENTRY_HDR_BYTES),
        .POOL_HDR_BYTES(POOL_HDR_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_func(s_axis_tdata[0]),
        .i_request_size(s_axis_tdata[16:1]),
        .i_release_addr(s_axis_tdata[32:17]),
        .i_cmd(cmd), .o_stat(stat),
        .o_granted_addr(granted), .o_status(status)
    );

    assign m_axis_tdata = {6'd0, status, granted};
endmodule
